@@ src/mslr_pkg.sv @@
// shared types, codes and initial stream table for the lehmer generator bank
package mslr_pkg;

   localparam int SEED_W  = 31;
   localparam int CNT_W   = 16;
   localparam int BND_W   = 8;
   localparam int TAG_W   = 4;
   localparam int ENTRY_W = SEED_W + CNT_W + BND_W + TAG_W;

   localparam logic [SEED_W-1:0] LCG_MUL = 31'd16807;
   localparam logic [SEED_W-1:0] LCG_MOD = 31'h7FFF_FFFF;

   localparam logic [2:0] CMD_NEXT_INT  = 3'd0;
   localparam logic [2:0] CMD_ADVANCE   = 3'd1;
   localparam logic [2:0] CMD_ROW_START = 3'd2;
   localparam logic [2:0] CMD_ROW_STOP  = 3'd3;
   localparam logic [2:0] CMD_RESET_ALL = 3'd4;
   localparam logic [2:0] CMD_READ_SEED = 3'd5;

   localparam logic [TAG_W-1:0] TAB_NONE      = 4'd0;
   localparam logic [TAG_W-1:0] TAB_PART      = 4'd1;
   localparam logic [TAG_W-1:0] TAB_PARTSUPP  = 4'd2;
   localparam logic [TAG_W-1:0] TAB_ORDERS    = 4'd5;
   localparam logic [TAG_W-1:0] TAB_LINEITEM  = 4'd6;
   localparam logic [TAG_W-1:0] TAB_ORDERLINE = 4'd7;
   localparam logic [TAG_W-1:0] TAB_PART_PSUP = 4'd8;

   localparam logic [1:0] WR_KEEP   = 2'd0;
   localparam logic [1:0] WR_NEXT   = 2'd1;
   localparam logic [1:0] WR_CLRCNT = 2'd2;
   localparam logic [1:0] WR_ROM    = 2'd3;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [BND_W-1:0]  bound;
      logic [CNT_W-1:0]  count;
      logic [SEED_W-1:0] seed;
   } entry_type;

   typedef struct packed {
      logic       latch_in;
      logic       rd_en;
      logic       use_k;
      logic       load;
      logic       mul_en;
      logic       mul_sq;
      logic       red_v;
      logic       red_m;
      logic       sc1;
      logic       sc2;
      logic       sc3;
      logic       div;
      logic       fix;
      logic       wr_en;
      logic [1:0] wr_mode;
      logic       k_inc;
      logic       rsp_load;
   } ctrl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       cnt_zero;
      logic       cnt_bit0;
      logic       k_last;
   } status_type;

   function automatic entry_type mk(input logic [TAG_W-1:0] tag,
                                    input logic [SEED_W-1:0] seed,
                                    input logic [BND_W-1:0] bound);
      entry_type e;
      e.tag   = tag;
      e.bound = bound;
      e.count = '0;
      e.seed  = seed;
      return e;
   endfunction

   function automatic entry_type rom_entry(input logic [5:0] idx,
                                           input logic [7:0] lines,
                                           input logic [7:0] colors);
      entry_type e;
      case (idx)
         6'd0:  e = mk(4'd1, 31'd1, 8'd1);
         6'd1:  e = mk(4'd1, 31'd46831694, 8'd1);
         6'd2:  e = mk(4'd1, 31'd1841581359, 8'd1);
         6'd3:  e = mk(4'd1, 31'd1193163244, 8'd1);
         6'd4:  e = mk(4'd1, 31'd727633698, 8'd1);
         6'd5:  e = mk(4'd0, 31'd933588178, 8'd1);
         6'd6:  e = mk(4'd1, 31'd804159733, 8'd2);
         6'd7:  e = mk(4'd2, 31'd1671059989, 8'd4);
         6'd8:  e = mk(4'd2, 31'd1051288424, 8'd4);
         6'd9:  e = mk(4'd2, 31'd1961692154, 8'd2);
         6'd10: e = mk(4'd5, 31'd1227283347, 8'd1);
         6'd11: e = mk(4'd5, 31'd1171034773, 8'd1);
         6'd12: e = mk(4'd5, 31'd276090261, 8'd2);
         6'd13: e = mk(4'd5, 31'd1066728069, 8'd1);
         6'd14: e = mk(4'd6, 31'd209208115, lines);
         6'd15: e = mk(4'd6, 31'd554590007, lines);
         6'd16: e = mk(4'd6, 31'd721958466, lines);
         6'd17: e = mk(4'd6, 31'd1371272478, lines);
         6'd18: e = mk(4'd6, 31'd675466456, lines);
         6'd19: e = mk(4'd6, 31'd1808217256, lines);
         6'd20: e = mk(4'd6, 31'd2095021727, lines);
         6'd21: e = mk(4'd6, 31'd1769349045, lines);
         6'd22: e = mk(4'd6, 31'd904914315, lines);
         6'd23: e = mk(4'd6, 31'd373135028, lines);
         6'd24: e = mk(4'd6, 31'd717419739, lines);
         6'd25: e = mk(4'd6, 31'd1095462486, {lines[6:0], 1'b0});
         6'd26: e = mk(4'd4, 31'd881155353, 8'd9);
         6'd27: e = mk(4'd4, 31'd1489529863, 8'd1);
         6'd28: e = mk(4'd4, 31'd1521138112, 8'd3);
         6'd29: e = mk(4'd4, 31'd298370230, 8'd1);
         6'd30: e = mk(4'd4, 31'd1140279430, 8'd1);
         6'd31: e = mk(4'd4, 31'd1335826707, 8'd2);
         6'd32: e = mk(4'd3, 31'd706178559, 8'd9);
         6'd33: e = mk(4'd3, 31'd110356601, 8'd1);
         6'd34: e = mk(4'd3, 31'd884434366, 8'd3);
         6'd35: e = mk(4'd3, 31'd962338209, 8'd1);
         6'd36: e = mk(4'd3, 31'd1341315363, 8'd2);
         6'd37: e = mk(4'd1, 31'd709314158, colors);
         6'd38: e = mk(4'd5, 31'd591449447, 8'd1);
         6'd39: e = mk(4'd6, 31'd431918286, 8'd1);
         6'd40: e = mk(4'd5, 31'd851767375, 8'd1);
         6'd41: e = mk(4'd9, 31'd606179079, 8'd2);
         6'd42: e = mk(4'd10, 31'd1500869201, 8'd2);
         6'd43: e = mk(4'd5, 31'd1434868289, 8'd1);
         6'd44: e = mk(4'd3, 31'd263032577, 8'd1);
         6'd45: e = mk(4'd3, 31'd753643799, 8'd1);
         6'd46: e = mk(4'd3, 31'd202794285, 8'd1);
         6'd47: e = mk(4'd3, 31'd715851524, 8'd1);
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

@@ src/mslr_ram.sv @@
// generic single write port ram with registered read
module mslr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/mslr_dp.sv @@
// datapath: stream store, shared modular multiplier, scaler and result register
module mslr_dp #(
   parameter int NUM_STREAMS     = 48,
   parameter int LINES_PER_ORDER = 7,
   parameter int COLOR_COUNT     = 92,
   parameter int COUNT_BITS      = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mslr_pkg::ctrl_type        ctrl,
   output mslr_pkg::status_type      status,
   input  logic [2:0]                in_command,
   input  logic [5:0]                in_stream_index,
   input  logic signed [31:0]        in_range_low,
   input  logic signed [31:0]        in_range_high,
   input  logic [39:0]               in_jump_count,
   input  logic [3:0]                in_table_code,
   output logic signed [32:0]        out_random_value,
   output logic [30:0]               out_seed_now
);

   localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam logic [7:0] LINES_B  = 8'(LINES_PER_ORDER);
   localparam logic [7:0] COLORS_B = 8'(COLOR_COUNT);

   logic [2:0]             cmd_ff;
   logic [IDX_W-1:0]       sel_ff;
   logic signed [32:0]     lo_ff;
   logic [32:0]            r_ff;
   logic                   quirk_ff;
   logic [COUNT_BITS-1:0]  jump_ff;
   logic [3:0]             tab_ff;
   logic [3:0]             child_ff;
   logic [IDX_W-1:0]       k_ff;
   mslr_pkg::entry_type    cur_ff;
   logic [30:0]            val_ff;
   logic [30:0]            mult_ff;
   logic [COUNT_BITS-1:0]  cnt_ff;
   logic [61:0]            prod_ff;
   logic [46:0]            pa_ff;
   logic [47:0]            pb_ff;
   logic [63:0]            x_ff;
   logic [33:0]            q_ff;
   logic signed [32:0]     rv_ff;
   logic signed [32:0]     rsp_rv_ff;
   logic [30:0]            rsp_seed_ff;

   mslr_pkg::entry_type    rd_entry;
   mslr_pkg::entry_type    wr_entry;
   logic [IDX_W-1:0]       addr;
   logic [31:0]            red_sum;
   logic [30:0]            red_val;
   logic signed [31:0]     lo_s;
   logic signed [31:0]     hi_s;
   logic [3:0]             tab_in;
   logic [COUNT_BITS-1:0]  cnt_in;
   logic [30:0]            mul_b;

   assign addr = ctrl.use_k ? k_ff : sel_ff;

   always_comb begin
      wr_entry = cur_ff;
      wr_entry.seed = val_ff;
      case (ctrl.wr_mode)
         mslr_pkg::WR_KEEP:   wr_entry.count = cur_ff.count;
         mslr_pkg::WR_NEXT:   wr_entry.count = cur_ff.count + 16'd1;
         mslr_pkg::WR_CLRCNT: wr_entry.count = '0;
         mslr_pkg::WR_ROM:    wr_entry = mslr_pkg::rom_entry(6'(k_ff), LINES_B, COLORS_B);
         default:             wr_entry = cur_ff;
      endcase
   end

   mslr_ram #(
      .WIDTH (mslr_pkg::ENTRY_W),
      .DEPTH (NUM_STREAMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctrl.wr_en),
      .wr_addr (addr),
      .wr_data (wr_entry),
      .rd_en   (ctrl.rd_en),
      .rd_addr (addr),
      .rd_data (rd_entry)
   );

   // modular reduction by 2^31-1
   always_comb begin
      red_sum = {1'b0, prod_ff[61:31]} + {1'b0, prod_ff[30:0]};
      if (red_sum >= {1'b0, mslr_pkg::LCG_MOD}) begin
         red_val = 31'(red_sum - {1'b0, mslr_pkg::LCG_MOD});
      end else begin
         red_val = red_sum[30:0];
      end
   end

   always_comb begin
      if (in_range_low > in_range_high) begin
         lo_s = in_range_high;
         hi_s = in_range_low;
      end else begin
         lo_s = in_range_low;
         hi_s = in_range_high;
      end
      if (in_table_code == mslr_pkg::TAB_ORDERLINE) begin
         tab_in = mslr_pkg::TAB_ORDERS;
      end else if (in_table_code == mslr_pkg::TAB_PART_PSUP) begin
         tab_in = mslr_pkg::TAB_PART;
      end else begin
         tab_in = in_table_code;
      end
   end

   always_comb begin
      cnt_in = '0;
      if (cmd_ff == mslr_pkg::CMD_ADVANCE) begin
         cnt_in = jump_ff;
      end else if ((rd_entry.tag == tab_ff || rd_entry.tag == child_ff)
                   && rd_entry.count < {8'd0, rd_entry.bound}) begin
         cnt_in = COUNT_BITS'(rd_entry.bound - rd_entry.count[7:0]);
      end
   end

   assign mul_b = ctrl.mul_sq ? mult_ff : val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (ctrl.k_inc) begin
         k_ff <= (k_ff == IDX_W'(NUM_STREAMS - 1)) ? '0 : k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_in) begin
         cmd_ff   <= in_command;
         sel_ff   <= ({1'b0, in_stream_index} < 7'(NUM_STREAMS))
                     ? in_stream_index[IDX_W-1:0] : '0;
         lo_ff    <= {lo_s[31], lo_s};
         r_ff     <= ({hi_s[31], hi_s} - {lo_s[31], lo_s}) + 33'd1;
         quirk_ff <= (lo_s == 32'sd0) && (hi_s == 32'sh7FFF_FFFF);
         jump_ff  <= COUNT_BITS'(in_jump_count);
         tab_ff   <= tab_in;
         child_ff <= (tab_in == mslr_pkg::TAB_PART) ? mslr_pkg::TAB_PARTSUPP :
                     (tab_in == mslr_pkg::TAB_ORDERS) ? mslr_pkg::TAB_LINEITEM :
                     mslr_pkg::TAB_NONE;
         rv_ff    <= '0;
      end
      if (ctrl.load) begin
         cur_ff  <= rd_entry;
         val_ff  <= rd_entry.seed;
         mult_ff <= mslr_pkg::LCG_MUL;
         cnt_ff  <= cnt_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= mult_ff * mul_b;
      end
      if (ctrl.red_v) begin
         val_ff <= red_val;
      end
      if (ctrl.red_m) begin
         mult_ff <= red_val;
         cnt_ff  <= cnt_ff >> 1;
      end
      if (ctrl.sc1) begin
         pa_ff <= val_ff * r_ff[15:0];
      end
      if (ctrl.sc2) begin
         pb_ff <= val_ff * r_ff[32:16];
      end
      if (ctrl.sc3) begin
         x_ff <= {17'd0, pa_ff} + {pb_ff, 16'd0};
         q_ff <= '0;
      end
      if (ctrl.div) begin
         q_ff <= q_ff + 34'(x_ff[63:31]);
         x_ff <= 64'(x_ff[63:31]) + 64'(x_ff[30:0]);
      end
      if (ctrl.fix) begin
         if (x_ff >= 64'(mslr_pkg::LCG_MOD)) begin
            rv_ff <= quirk_ff ? -$signed(33'(q_ff + 34'd1)) : lo_ff + $signed(33'(q_ff + 34'd1));
         end else begin
            rv_ff <= quirk_ff ? -$signed(33'(q_ff)) : lo_ff + $signed(33'(q_ff));
         end
      end
      if (ctrl.rsp_load) begin
         rsp_rv_ff   <= rv_ff;
         rsp_seed_ff <= cur_ff.seed;
      end
   end

   assign status.cmd      = cmd_ff;
   assign status.cnt_zero = (cnt_ff == '0);
   assign status.cnt_bit0 = cnt_ff[0];
   assign status.k_last   = (k_ff == IDX_W'(NUM_STREAMS - 1));

   assign out_random_value = rsp_rv_ff;
   assign out_seed_now     = rsp_seed_ff;

endmodule

@@ src/mslr_ctrl.sv @@
// controller state machine sequencing store sweeps, jump-ahead and scaling
module mslr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  mslr_pkg::status_type  status,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output mslr_pkg::ctrl_type    ctrl
);

   localparam logic [4:0] S_CLR    = 5'd0;
   localparam logic [4:0] S_IDLE   = 5'd1;
   localparam logic [4:0] S_RD     = 5'd2;
   localparam logic [4:0] S_LD     = 5'd3;
   localparam logic [4:0] S_NMUL   = 5'd4;
   localparam logic [4:0] S_NRED   = 5'd5;
   localparam logic [4:0] S_SC1    = 5'd6;
   localparam logic [4:0] S_SC2    = 5'd7;
   localparam logic [4:0] S_SC3    = 5'd8;
   localparam logic [4:0] S_DIV    = 5'd9;
   localparam logic [4:0] S_FIX    = 5'd10;
   localparam logic [4:0] S_JCHK   = 5'd11;
   localparam logic [4:0] S_JMV    = 5'd12;
   localparam logic [4:0] S_JRV    = 5'd13;
   localparam logic [4:0] S_JMM    = 5'd14;
   localparam logic [4:0] S_JRM    = 5'd15;
   localparam logic [4:0] S_WR     = 5'd16;
   localparam logic [4:0] S_RPT_RD = 5'd17;
   localparam logic [4:0] S_RPT_LD = 5'd18;
   localparam logic [4:0] S_OUT    = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [1:0] div_ff, div_in;
   logic       boot_ff, boot_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       sweep;

   assign sweep = (status.cmd == mslr_pkg::CMD_ROW_START)
                  || (status.cmd == mslr_pkg::CMD_ROW_STOP);

   always_comb begin
      state_in     = state_ff;
      div_in       = div_ff;
      boot_in      = boot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctrl         = '0;
      ctrl.use_k   = sweep;
      case (state_ff)
         S_CLR: begin
            ctrl.use_k   = 1'b1;
            ctrl.wr_en   = 1'b1;
            ctrl.wr_mode = mslr_pkg::WR_ROM;
            ctrl.k_inc   = 1'b1;
            if (status.k_last) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_RPT_RD;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               ctrl.latch_in = 1'b1;
               state_in      = S_RD;
            end
         end
         S_RD: begin
            if (status.cmd == mslr_pkg::CMD_RESET_ALL) begin
               state_in = S_CLR;
            end else if (status.cmd == mslr_pkg::CMD_NEXT_INT
                         || status.cmd == mslr_pkg::CMD_ADVANCE || sweep) begin
               ctrl.rd_en = 1'b1;
               state_in   = S_LD;
            end else begin
               state_in = S_RPT_RD;
            end
         end
         S_LD: begin
            ctrl.load = 1'b1;
            case (status.cmd)
               mslr_pkg::CMD_NEXT_INT:  state_in = S_NMUL;
               mslr_pkg::CMD_ROW_START: state_in = S_WR;
               default:                 state_in = S_JCHK;
            endcase
         end
         S_NMUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = S_NRED;
         end
         S_NRED: begin
            ctrl.red_v = 1'b1;
            state_in   = S_SC1;
         end
         S_SC1: begin
            ctrl.sc1 = 1'b1;
            state_in = S_SC2;
         end
         S_SC2: begin
            ctrl.sc2 = 1'b1;
            state_in = S_SC3;
         end
         S_SC3: begin
            ctrl.sc3 = 1'b1;
            div_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            ctrl.div = 1'b1;
            div_in   = div_ff + 2'd1;
            if (div_ff == 2'd2) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            ctrl.fix = 1'b1;
            state_in = S_WR;
         end
         S_JCHK: begin
            if (status.cnt_zero) begin
               state_in = S_WR;
            end else if (status.cnt_bit0) begin
               state_in = S_JMV;
            end else begin
               state_in = S_JMM;
            end
         end
         S_JMV: begin
            ctrl.mul_en = 1'b1;
            state_in    = S_JRV;
         end
         S_JRV: begin
            ctrl.red_v = 1'b1;
            state_in   = S_JMM;
         end
         S_JMM: begin
            ctrl.mul_en = 1'b1;
            ctrl.mul_sq = 1'b1;
            state_in    = S_JRM;
         end
         S_JRM: begin
            ctrl.red_m = 1'b1;
            state_in   = S_JCHK;
         end
         S_WR: begin
            ctrl.wr_en = 1'b1;
            case (status.cmd)
               mslr_pkg::CMD_NEXT_INT:  ctrl.wr_mode = mslr_pkg::WR_NEXT;
               mslr_pkg::CMD_ROW_START: ctrl.wr_mode = mslr_pkg::WR_CLRCNT;
               default:                 ctrl.wr_mode = mslr_pkg::WR_KEEP;
            endcase
            if (sweep) begin
               ctrl.k_inc = 1'b1;
               state_in   = status.k_last ? S_RPT_RD : S_RD;
            end else begin
               state_in = S_RPT_RD;
            end
         end
         S_RPT_RD: begin
            ctrl.use_k = 1'b0;
            ctrl.rd_en = 1'b1;
            state_in   = S_RPT_LD;
         end
         S_RPT_LD: begin
            ctrl.load = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctrl.rsp_load = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         div_ff       <= '0;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_ff       <= div_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

@@ src/multi_stream_lehmer_rng_skip.sv @@
// top level: bank of lehmer generators with jump-ahead and scaled draws
//
// req channel carries one command per transfer; rsp channel returns exactly
// one result per command: the scaled value (next_int only, else zero) and the
// selected stream's seed after the command.
// one command is processed at a time; the store has one write and one read port on a shared address.
// advance and row_stop jump seeds ahead by square-and-multiply on the shared multiplier, which next_int also uses.
// the next command can be taken in the cycle after the result register loads.
// after reset the store is loaded from the initial table, one stream per
// cycle, for all NUM_STREAMS streams; req_tready stays low meanwhile.
// the result sits in an output register; a new command is taken while it
// waits, but the next result holds back until the receiver takes it.
module multi_stream_lehmer_rng_skip #(
   parameter int NUM_STREAMS     = 48,
   parameter int LINES_PER_ORDER = 7,
   parameter int COLOR_COUNT     = 92,
   parameter int COUNT_BITS      = 40
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command, stream_index, range_low, range_high, jump_count, table_code
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // random_value, seed_now
   output logic [63:0]  rsp_tdata
);

   mslr_pkg::ctrl_type   ctrl;
   mslr_pkg::status_type status;
   logic signed [32:0]   random_value;
   logic [30:0]          seed_now;

   mslr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   mslr_dp #(
      .NUM_STREAMS     (NUM_STREAMS),
      .LINES_PER_ORDER (LINES_PER_ORDER),
      .COLOR_COUNT     (COLOR_COUNT),
      .COUNT_BITS      (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .in_command       (req_tdata[2:0]),
      .in_stream_index  (req_tdata[8:3]),
      .in_range_low     (req_tdata[40:9]),
      .in_range_high    (req_tdata[72:41]),
      .in_jump_count    (req_tdata[112:73]),
      .in_table_code    (req_tdata[116:113]),
      .out_random_value (random_value),
      .out_seed_now     (seed_now)
   );

   assign rsp_tdata = {seed_now, random_value};

   a_no_accept_while_writing: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !ctrl.wr_en)
      else $error("store written while idle");

   a_seed_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:33] != 31'h7FFF_FFFF)
      else $error("seed reached modulus");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while busy");

endmodule
